>>> src/sdpq_pkg.sv
`timescale 1ns / 1ps

package sdpq_pkg;

   // fixed field widths of the request and response channels
   localparam int KEY_W    = 16;
   localparam int TAG_W    = 8;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 5;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_REMOVE = 1'b1
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;   // capture the incoming request
      logic exec;   // apply the captured request and load the response register
   } cmd_type;

endpackage

>>> src/sdpq_req_if.sv
`timescale 1ns / 1ps

interface sdpq_req_if;
   logic                          valid;
   logic                          ready;
   logic                          op;
   logic [sdpq_pkg::KEY_W-1:0]    key;
   logic [sdpq_pkg::TAG_W-1:0]    tag;

   modport source (output valid, output op, output key, output tag, input ready);
   modport sink   (input valid, input op, input key, input tag, output ready);
endinterface

>>> src/sdpq_rsp_if.sv
`timescale 1ns / 1ps

interface sdpq_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [sdpq_pkg::KEY_W-1:0]    out_key;
   logic [sdpq_pkg::TAG_W-1:0]    out_tag;
   logic [sdpq_pkg::STATUS_W-1:0] status;
   logic [sdpq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output out_key, output out_tag, output status,
                   output occupancy, input ready);
   modport sink   (input valid, input out_key, input out_tag, input status,
                   input occupancy, output ready);
endinterface

>>> src/sdpq_ctrl.sv
`timescale 1ns / 1ps

module sdpq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output sdpq_pkg::cmd_type cmd
);
   import sdpq_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      out_valid_ff;

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = out_valid_ff;

   // exec waits until the response register is free or being drained
   assign cmd.load = in_valid && (state_ff == S_IDLE);
   assign cmd.exec = (state_ff == S_EXEC) && (!out_valid_ff || out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (cmd.load) begin
                  state_ff <= S_EXEC;
               end
               if (out_valid_ff && out_ready) begin
                  out_valid_ff <= 1'b0;
               end
            end
            S_EXEC: begin
               if (cmd.exec) begin
                  state_ff     <= S_IDLE;
                  out_valid_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && cmd.exec))
      else $error("load and exec in the same cycle");

   a_load_to_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_EXEC))
      else $error("accepted request not taken into exec");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> (out_valid_ff && state_ff == S_IDLE))
      else $error("exec did not present a response");

endmodule

>>> src/sdpq_datapath.sv
`timescale 1ns / 1ps

module sdpq_datapath #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sdpq_pkg::cmd_type               cmd,
   input  logic                            in_op,
   input  logic [sdpq_pkg::KEY_W-1:0]      in_key,
   input  logic [sdpq_pkg::TAG_W-1:0]      in_tag,
   output logic [sdpq_pkg::KEY_W-1:0]      out_key,
   output logic [sdpq_pkg::TAG_W-1:0]      out_tag,
   output logic [sdpq_pkg::STATUS_W-1:0]   out_status,
   output logic [sdpq_pkg::OCC_W-1:0]      out_occupancy
);
   import sdpq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

   // captured request
   op_type              op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [TAG_W-1:0]    tag_ff;

   // cell chain, cell 0 holds the largest key
   logic [KEY_BITS-1:0] cell_key_ff [CAPACITY];
   logic [TAG_W-1:0]    cell_tag_ff [CAPACITY];
   logic [KEY_BITS-1:0] cell_key_in [CAPACITY];
   logic [TAG_W-1:0]    cell_tag_in [CAPACITY];
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;

   // response register
   logic [KEY_W-1:0]    out_key_ff;
   logic [TAG_W-1:0]    out_tag_ff;
   status_type          status_ff;
   logic [OCC_W-1:0]    occ_ff;

   logic [KEY_W-1:0]    res_key;
   logic [TAG_W-1:0]    res_tag;
   status_type          res_status;

   // neighbour views for shifting
   logic [KEY_BITS-1:0] up_key   [CAPACITY];
   logic [TAG_W-1:0]    up_tag   [CAPACITY];
   logic [KEY_BITS-1:0] down_key [CAPACITY];
   logic [TAG_W-1:0]    down_tag [CAPACITY];
   logic [CAPACITY-1:0] take;
   logic [CAPACITY-1:0] take_prev;

   always_comb begin
      up_key[0] = key_ff;
      up_tag[0] = tag_ff;
      for (int i = 1; i < CAPACITY; i++) begin
         up_key[i] = cell_key_ff[i-1];
         up_tag[i] = cell_tag_ff[i-1];
      end
      for (int i = 0; i < CAPACITY - 1; i++) begin
         down_key[i] = cell_key_ff[i+1];
         down_tag[i] = cell_tag_ff[i+1];
      end
      down_key[CAPACITY-1] = cell_key_ff[CAPACITY-1];
      down_tag[CAPACITY-1] = cell_tag_ff[CAPACITY-1];
   end

   // a cell is displaced when empty or its key is not above the new key
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         take[i] = (CNT_W'(i) >= count_ff) || (cell_key_ff[i] <= key_ff);
      end
   end

   assign take_prev = {take[CAPACITY-2:0], 1'b0};

   always_comb begin
      res_key    = '0;
      res_tag    = '0;
      res_status = ST_OK;
      count_in   = count_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         cell_key_in[i] = cell_key_ff[i];
         cell_tag_in[i] = cell_tag_ff[i];
      end
      unique case (op_ff)
         OP_INSERT: begin
            if (count_ff == CAP_CNT) begin
               res_status = ST_FULL;
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (take[i]) begin
                     // first displaced cell takes the new entry, the rest move down
                     cell_key_in[i] = take_prev[i] ? up_key[i] : key_ff;
                     cell_tag_in[i] = take_prev[i] ? up_tag[i] : tag_ff;
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (count_ff == '0) begin
               res_status = ST_EMPTY;
            end else begin
               res_key = KEY_W'(cell_key_ff[0]);
               res_tag = cell_tag_ff[0];
               for (int i = 0; i < CAPACITY; i++) begin
                  cell_key_in[i] = down_key[i];
                  cell_tag_in[i] = down_tag[i];
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            res_status = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(in_op);
         key_ff <= KEY_BITS'(in_key);
         tag_ff <= in_tag;
      end
      if (cmd.exec) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cell_key_ff[i] <= cell_key_in[i];
            cell_tag_ff[i] <= cell_tag_in[i];
         end
         out_key_ff <= res_key;
         out_tag_ff <= res_tag;
         status_ff  <= res_status;
         occ_ff     <= OCC_W'(count_in);
      end
   end

   assign out_key       = out_key_ff;
   assign out_tag       = out_tag_ff;
   assign out_status    = status_ff;
   assign out_occupancy = occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == OP_INSERT && count_ff != CAP_CNT)
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the queue");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == OP_REMOVE && count_ff == '0)
      |=> (status_ff == ST_EMPTY && occ_ff == '0 && count_ff == '0))
      else $error("remove on empty queue mishandled");

endmodule

>>> src/sorted_descending_priority_queue.sv
`timescale 1ns / 1ps

// bounded priority queue holding up to CAPACITY key/tag entries sorted by key,
// largest first; among equal keys the newest entry sits nearest the head
// req channel: op (insert or remove), key and tag; one request is taken
//    whenever req.ready is high, which is while no request is in flight
// rsp channel: exactly one response per request, carrying the removed key and
//    tag (zero otherwise), a status code and the occupancy after the request
// sequencing: an accepted request is held in the request register and applied to
//    the cell chain and response register once that register is free; no new
//    request is accepted before then, as set by the accept/update sequence of the
//    controller; each cell compares its key with the new one in parallel
// receiver stall: a waiting response sits in the response register, the next
//    request is still accepted and its update is held until that register drains
// reset: synchronous, clears the entry count and controller state only, so the
//    queue is empty at once; no clearing pass is run, the cells keep stale contents
module sorted_descending_priority_queue #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   sdpq_req_if.sink   req,
   sdpq_rsp_if.source rsp
);
   import sdpq_pkg::*;

   // controller to datapath command bundle
   cmd_type cmd;

   // sequencing: accept, update, hold response
   sdpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .cmd       (cmd)
   );

   // request capture, sorted cell chain and response register
   sdpq_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .in_op         (req.op),
      .in_key        (req.key),
      .in_tag        (req.tag),
      .out_key       (rsp.out_key),
      .out_tag       (rsp.out_tag),
      .out_status    (rsp.status),
      .out_occupancy (rsp.occupancy)
   );

endmodule

>>> tb/sorted_descending_priority_queue_checker.sv
`timescale 1ns / 1ps

module sorted_descending_priority_queue_checker #(
   parameter int CAPACITY = 16,
   parameter int KEY_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic                          req_op,
   input  logic [sdpq_pkg::KEY_W-1:0]    req_key,
   input  logic [sdpq_pkg::TAG_W-1:0]    req_tag,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [sdpq_pkg::KEY_W-1:0]    rsp_out_key,
   input  logic [sdpq_pkg::TAG_W-1:0]    rsp_out_tag,
   input  logic [sdpq_pkg::STATUS_W-1:0] rsp_status,
   input  logic [sdpq_pkg::OCC_W-1:0]    rsp_occupancy,
   output int                            mismatch_count,
   output int                            awaiting_count
);
   import sdpq_pkg::*;

   localparam logic [KEY_W-1:0] KEY_MASK =
      (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : KEY_W'((64'd1 << KEY_BITS) - 64'd1);

   typedef struct packed {
      logic [KEY_W-1:0] out_key;
      logic [TAG_W-1:0] out_tag;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } queue_result_type;

   // shadow copy of the sorted store
   logic [KEY_W-1:0] shadow_keys [CAPACITY];
   logic [TAG_W-1:0] shadow_tags [CAPACITY];
   int               shadow_count = 0;

   queue_result_type due_results [$];
   int               errors = 0;

   function automatic queue_result_type apply_request(input op_type op,
                                                      input logic [KEY_W-1:0] key,
                                                      input logic [TAG_W-1:0] tag);
      queue_result_type r;
      logic [KEY_W-1:0] k;
      int               pos;
      r = '0;
      r.status = ST_OK;
      k = key & KEY_MASK;
      if (op == OP_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            r.status = ST_FULL;
         end else begin
            // first stored key not above the new one, newest first on ties
            pos = shadow_count;
            for (int i = 0; i < shadow_count; i++)
               if (pos == shadow_count && shadow_keys[i] <= k) pos = i;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_keys[i] = shadow_keys[i-1];
               shadow_tags[i] = shadow_tags[i-1];
            end
            shadow_keys[pos] = k;
            shadow_tags[pos] = tag;
            shadow_count++;
         end
      end else begin
         if (shadow_count == 0) begin
            r.status = ST_EMPTY;
         end else begin
            r.out_key = shadow_keys[0];
            r.out_tag = shadow_tags[0];
            for (int i = 1; i < shadow_count; i++) begin
               shadow_keys[i-1] = shadow_keys[i];
               shadow_tags[i-1] = shadow_tags[i];
            end
            shadow_count--;
         end
      end
      r.occupancy = OCC_W'(shadow_count);
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      queue_result_type want;
      if (reset) begin
         due_results.delete();
         shadow_count = 0;
      end else begin
         // responses first: a response never belongs to a request taken at this edge
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %s %0h %0h %0d %0d",
                        $time, "key/tag/status/occupancy", rsp_out_key, rsp_out_tag,
                        rsp_status, rsp_occupancy);
               errors++;
            end else begin
               want = due_results.pop_front();
               compare_field("out_key", 32'(want.out_key), 32'(rsp_out_key));
               compare_field("out_tag", 32'(want.out_tag), 32'(rsp_out_tag));
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("occupancy", 32'(want.occupancy), 32'(rsp_occupancy));
            end
         end
         if (req_valid && req_ready)
            due_results.push_back(apply_request(op_type'(req_op), req_key, req_tag));
      end
      mismatch_count <= errors;
      awaiting_count <= due_results.size();
   end

endmodule

>>> tb/sorted_descending_priority_queue_tb.sv
`timescale 1ns / 1ps

module sorted_descending_priority_queue_tb;
   import sdpq_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int KEY_BITS    = 16;
   // random requests per idling phase, four phases
   localparam int PHASE_ITEMS = 175;
   // length of the long receiver hold-off, in cycles
   localparam int LONG_HOLD   = 300;
   // far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;

   logic clock;
   logic reset = 1'b1;

   sdpq_req_if req_bus ();
   sdpq_rsp_if rsp_bus ();

   int mismatch_count;
   int awaiting_count;
   int cycle_count = 0;

   // idling percentages, changed between phases
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;

   // long hold-off hand-over: the stimulus raises the request count,
   // the receiver process serves it and counts the cycles itself
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;

   sorted_descending_priority_queue #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   sorted_descending_priority_queue_checker #(
      .CAPACITY(CAPACITY),
      .KEY_BITS(KEY_BITS)
   ) i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_bus.valid),
      .req_ready     (req_bus.ready),
      .req_op        (req_bus.op),
      .req_key       (req_bus.key),
      .req_tag       (req_bus.tag),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_out_key   (rsp_bus.out_key),
      .rsp_out_tag   (rsp_bus.out_tag),
      .rsp_status    (rsp_bus.status),
      .rsp_occupancy (rsp_bus.occupancy),
      .mismatch_count(mismatch_count),
      .awaiting_count(awaiting_count)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // receiver: random stalls, or a long hold-off when one is asked for
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served++;
         hold_left = LONG_HOLD - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // offer one request, with random idle cycles in front, and wait for the accept
   task automatic offer_request(input op_type op, input logic [KEY_W-1:0] key,
                                input logic [TAG_W-1:0] tag);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.key   <= key;
      req_bus.tag   <= tag;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // random mix: the insert share swings so the queue runs both full and empty,
   // keys are drawn to give plenty of ties and extremes
   task automatic random_requests(input int count);
      int               insert_pct;
      logic [KEY_W-1:0] key;
      op_type           op;
      insert_pct = 50;
      for (int n = 0; n < count; n++) begin
         if (n % 20 == 0) insert_pct = 25 * ($urandom_range(2) + 1);
         case ($urandom_range(3))
            0: begin
               key = KEY_W'($urandom);
            end
            1: begin
               key = KEY_W'($urandom_range(7));
            end
            2: begin
               key = $urandom_range(1) ? {KEY_W{1'b1}} : '0;
            end
            default: begin
               key = KEY_W'($urandom_range(3)) << (KEY_W - 2);
            end
         endcase
         op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
         offer_request(op, key, TAG_W'($urandom));
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.op    <= OP_INSERT;
      req_bus.key   <= '0;
      req_bus.tag   <= '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: remove on an empty queue
      offer_request(OP_REMOVE, 16'hFFFF, 8'hFF);
      // tie with a single stored entry: the newer one must come out first
      offer_request(OP_INSERT, 16'h1234, 8'hA5);
      offer_request(OP_INSERT, 16'h1234, 8'h5A);
      offer_request(OP_REMOVE, '0, '0);
      offer_request(OP_REMOVE, '0, '0);
      offer_request(OP_REMOVE, '0, '0);
      // key extremes and a tie at the head
      offer_request(OP_INSERT, 16'h0000, 8'h00);
      offer_request(OP_INSERT, 16'hFFFF, 8'hFF);
      offer_request(OP_INSERT, 16'hFFFF, 8'h01);
      // fill up to capacity, then one insert that must be dropped
      for (int i = 3; i < CAPACITY; i++)
         offer_request(OP_INSERT, KEY_W'($urandom), TAG_W'(i));
      offer_request(OP_INSERT, 16'h8000, 8'h80);

      // phase without idling, starting with a long receiver hold-off so the
      // block backs up and drops its ready while requests keep coming
      hold_requests <= hold_requests + 1;
      random_requests(PHASE_ITEMS);

      // sender idling
      sender_idle_pct    <= 47;
      receiver_stall_pct <= 0;
      random_requests(PHASE_ITEMS);

      // receiver stalling
      sender_idle_pct    <= 0;
      receiver_stall_pct <= 47;
      random_requests(PHASE_ITEMS);

      // both sides idling now and then
      sender_idle_pct    <= 11;
      receiver_stall_pct <= 11;
      random_requests(PHASE_ITEMS);

      req_bus.valid <= 1'b0;

      // let the checker count the last request, drain all responses,
      // then a few cycles for anything stray
      @(posedge clock);
      while (awaiting_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sorted_descending_priority_queue.f
src/sdpq_pkg.sv
src/sdpq_req_if.sv
src/sdpq_rsp_if.sv
src/sdpq_ctrl.sv
src/sdpq_datapath.sv
src/sorted_descending_priority_queue.sv
tb/sorted_descending_priority_queue_checker.sv
tb/sorted_descending_priority_queue_tb.sv
